### rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/aedm_pkg.sv
// Shared constants for the echo delay mixer.
package aedm_pkg;

  // Configuration field widths
  localparam int DELAY_W = 13;
  localparam int GAIN_W  = 16;
  localparam int CLIP_W  = 15;

  // Fixed-point format of the gain
  localparam int FRAC_BITS = 15;
  localparam logic [GAIN_W:0] GAIN_ONE = 17'd32768;

  // Register file
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLIP  = 2'd2;

  // Register reset values
  localparam logic [DELAY_W-1:0] DELAY_RST = 13'd1024;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd16384;
  localparam logic [CLIP_W-1:0]  CLIP_RST  = 15'd32767;

endpackage

### rtl/core/audio_echo_delay_mix.sv
// Echo delay mixer: sample plus gain-scaled delayed sample, clipped.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+-------------------------------
//   input     | in        | in_valid/in_ready  | sample_in
//   output    | out       | out_valid/out_ready| sample_out
//   config    | in        | APB psel/penable   | paddr, pwdata, prdata
//
// One sample per cycle unless the output stalls; the delay line is read
// with the accept, then the multiply and the add and clip are registered.
// The delay line is one memory read and written at the accept edge.
// Reset clears pointers and fill count; no clearing pass over the memory.
// Each stage holds only while the stage after it is full and stalled.
module audio_echo_delay_mix #(
  parameter int MAX_DELAY    = 4096,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aedm_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);

  localparam int AW   = $clog2(MAX_DELAY);
  localparam int FCW  = $clog2(MAX_DELAY + 1);
  localparam int CMPW = (FCW > aedm_pkg::DELAY_W) ? FCW : aedm_pkg::DELAY_W;
  localparam int PW   = SAMPLE_WIDTH + aedm_pkg::GAIN_W + 2;
  localparam int ACCA = SAMPLE_WIDTH + aedm_pkg::FRAC_BITS + 4;
  localparam int ACCW = (ACCA > 32) ? ACCA : 32;
  localparam int LIMPAD = ACCW - aedm_pkg::CLIP_W - aedm_pkg::FRAC_BITS;

  // Configuration registers
  logic [aedm_pkg::DELAY_W-1:0] delay_samples;
  logic [aedm_pkg::GAIN_W-1:0]  echo_gain;
  logic [aedm_pkg::CLIP_W-1:0]  clip_level;
  logic [aedm_pkg::REG_IDX_W-1:0] reg_idx;
  logic cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[aedm_pkg::ADDR_W-1:2];
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= aedm_pkg::DELAY_RST;
      echo_gain     <= aedm_pkg::GAIN_RST;
      clip_level    <= aedm_pkg::CLIP_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        aedm_pkg::REG_DELAY: delay_samples <= pwdata[aedm_pkg::DELAY_W-1:0];
        aedm_pkg::REG_GAIN:  echo_gain     <= pwdata[aedm_pkg::GAIN_W-1:0];
        aedm_pkg::REG_CLIP:  clip_level    <= pwdata[aedm_pkg::CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      aedm_pkg::REG_DELAY: prdata = 32'(delay_samples);
      aedm_pkg::REG_GAIN:  prdata = 32'(echo_gain);
      aedm_pkg::REG_CLIP:  prdata = 32'(clip_level);
      default:             prdata = '0;
    endcase
  end

  // Pipeline flow control
  logic v1, v2;
  logic en1, en2, en3;
  logic accept;

  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign accept   = in_valid && in_ready;

  // Stage 0: delay line addressing
  logic [AW-1:0]   wp, wp_next;
  logic [FCW-1:0]  fill_count, fill_count_next;
  logic [CMPW-1:0] dly_raw, dly, wp_ext, rd_full;
  logic [AW-1:0]   rd_addr;
  logic            use0;

  always_comb begin
    dly_raw = CMPW'(delay_samples);
    if (dly_raw == '0) begin
      dly = CMPW'(1);
    end else if (dly_raw > CMPW'(MAX_DELAY)) begin
      dly = CMPW'(MAX_DELAY);
    end else begin
      dly = dly_raw;
    end
    wp_ext = CMPW'(wp);
    // wrap the read pointer back by the delay, modulo the line length
    if (wp_ext >= dly) begin
      rd_full = wp_ext - dly;
    end else begin
      rd_full = wp_ext + CMPW'(MAX_DELAY) - dly;
    end
    rd_addr = rd_full[AW-1:0];
    use0    = CMPW'(fill_count) >= dly;
    wp_next = (wp == AW'(MAX_DELAY - 1)) ? '0 : wp + 1'b1;
    fill_count_next = (fill_count == FCW'(MAX_DELAY)) ? fill_count
                                                      : fill_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      fill_count <= '0;
    end else if (accept) begin
      wp         <= wp_next;
      fill_count <= fill_count_next;
    end
  end

  // Delay line; read returns the entry before this cycle's write
  logic signed [SAMPLE_WIDTH-1:0] delay_mem [MAX_DELAY];
  logic signed [SAMPLE_WIDTH-1:0] rdata;

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata         <= delay_mem[rd_addr];
      delay_mem[wp] <= sample_in;
    end
  end

  // Stage 1: sample and delayed sample available
  logic signed [SAMPLE_WIDTH-1:0] x1;
  logic use1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1   <= sample_in;
      use1 <= use0;
    end
  end

  logic [aedm_pkg::GAIN_W:0]      gain_c;
  logic signed [SAMPLE_WIDTH-1:0] delayed;
  logic signed [PW-1:0]           prod;

  always_comb begin
    gain_c  = ({1'b0, echo_gain} > aedm_pkg::GAIN_ONE) ? aedm_pkg::GAIN_ONE
                                                       : {1'b0, echo_gain};
    delayed = use1 ? rdata : '0;
    prod    = PW'($signed({1'b0, gain_c})) * PW'(delayed);
  end

  // Stage 2: product registered
  logic signed [SAMPLE_WIDTH-1:0] x2;
  logic signed [PW-1:0]           prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      x2    <= x1;
      prod2 <= prod;
    end
  end

  // Stage 3: add in Q.15, clip symmetrically, floor shift
  logic signed [ACCW-1:0] acc, lim, acc_c, y;

  always_comb begin
    acc = (ACCW'(x2) <<< aedm_pkg::FRAC_BITS) + ACCW'(prod2);
    lim = $signed({{LIMPAD{1'b0}}, clip_level, {aedm_pkg::FRAC_BITS{1'b0}}});
    if (acc > lim) begin
      acc_c = lim;
    end else if (acc < -lim) begin
      acc_c = -lim;
    end else begin
      acc_c = acc;
    end
    y = acc_c >>> aedm_pkg::FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      sample_out <= y[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

### rtl/core/aedm_checker.sv
// Port-level checker for the echo delay mixer, bound to the top level.
`include "assert_macros.svh"

module aedm_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [aedm_pkg::ADDR_W-1:0]    paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata,
  input logic                           pready,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  logic cfg_wr, rd_delay, rd_gain, wr_delay, wr_gain;
  logic in_stall, out_stall, delay_match, gain_match;
  logic [31:0] pwdata_q;

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign wr_delay = cfg_wr && (paddr[aedm_pkg::ADDR_W-1:2] == aedm_pkg::REG_DELAY);
  assign wr_gain  = cfg_wr && (paddr[aedm_pkg::ADDR_W-1:2] == aedm_pkg::REG_GAIN);
  assign rd_delay = psel && !pwrite && (paddr[aedm_pkg::ADDR_W-1:2] == aedm_pkg::REG_DELAY);
  assign rd_gain  = psel && !pwrite && (paddr[aedm_pkg::ADDR_W-1:2] == aedm_pkg::REG_GAIN);

  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;

  // write data of the previous cycle, for the readback checks
  always_ff @(posedge clk) begin
    pwdata_q <= pwdata;
  end

  assign delay_match = prdata[aedm_pkg::DELAY_W-1:0] == pwdata_q[aedm_pkg::DELAY_W-1:0];
  assign gain_match  = prdata[aedm_pkg::GAIN_W-1:0] == pwdata_q[aedm_pkg::GAIN_W-1:0];

  `ASSERT_CLK_ALWAYS(a_reset_idle, rst |=> !out_valid, "result valid right after reset")

  `ASSERT_CLK(a_in_hold, in_stall |=> in_valid && $stable(sample_in), "request not held")

  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid && $stable(sample_out), "result not held")

  `ASSERT_CLK(a_delay_readback, wr_delay |=> !rd_delay || delay_match, "bad delay readback")

  `ASSERT_CLK(a_gain_readback, wr_gain |=> !rd_gain || gain_match, "bad gain readback")

endmodule

bind audio_echo_delay_mix aedm_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_aedm_checker (
  .clk        (clk),
  .rst        (rst),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .pready     (pready),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .sample_in  (sample_in),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);
